[hw/rtl/csvtok_pkg.sv]
// Types and constants shared by the CSV tokenizer modules.
package csvtok_pkg;

   localparam int RES_MAX = 8;
   localparam int RES_CNT_W = $clog2(RES_MAX + 1);

   localparam logic [1:0] KIND_BYTE    = 2'd0;
   localparam logic [1:0] KIND_FIELD   = 2'd1;
   localparam logic [1:0] KIND_RECORD  = 2'd2;
   localparam logic [1:0] KIND_VERSION = 2'd3;

   localparam logic [2:0] PH_LINE    = 3'd0;
   localparam logic [2:0] PH_COMMENT = 3'd1;
   localparam logic [2:0] PH_FSTART  = 3'd2;
   localparam logic [2:0] PH_BARE    = 3'd3;
   localparam logic [2:0] PH_QUOTED  = 3'd4;
   localparam logic [2:0] PH_QSEEN   = 3'd5;

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] BOM_0    = 8'hEF;
   localparam logic [7:0] BOM_1    = 8'hBB;
   localparam logic [7:0] BOM_2    = 8'hBF;

   localparam logic [29:0] VER_LIMIT = 30'd100000000;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [1:0]  token_kind;
      logic [7:0]  data_byte;
      logic [7:0]  column_index;
      logic        header_row;
      logic [29:0] format_version;
      logic        run_last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  bom;
      logic [2:0]  phase;
      logic        cr_wait;
      logic        hdr_seen;
      logic        ver_seen;
      logic [2:0]  wmp;
      logic        dig;
      logic [29:0] acc;
      logic [7:0]  fpos;
      logic        ffhb;
   } state_type;

   typedef rsp_type [RES_MAX-1:0] rsp_list_type;

endpackage

[hw/rtl/csvtok_core.sv]
// Next-state and result-list logic for one text byte.
module csvtok_core import csvtok_pkg::*; #(
   parameter logic [7:0] COL_CAP = 8'd255
) (
   input  state_type                st,
   input  req_type                  req,
   output state_type                st_in,
   output rsp_list_type             res,
   output logic [RES_CNT_W-1:0]     res_n
);

   typedef struct packed {
      state_type              s;
      rsp_list_type           r;
      logic [RES_CNT_W-1:0]   n;
   } ctx_type;

   function automatic logic [7:0] word_char(logic [2:0] i);
      unique case (i)
         3'd0: word_char = 8'h66;
         3'd1: word_char = 8'h6F;
         3'd2: word_char = 8'h72;
         3'd3: word_char = 8'h6D;
         3'd4: word_char = 8'h61;
         3'd5: word_char = 8'h74;
         default: word_char = 8'h20;
      endcase
   endfunction

   function automatic ctx_type put(ctx_type c, logic [1:0] k, logic [7:0] b,
                                   logic [7:0] col, logic h, logic [29:0] v);
      if (c.n < RES_CNT_W'(RES_MAX)) begin
         c.r[c.n[RES_CNT_W-2:0]].token_kind     = k;
         c.r[c.n[RES_CNT_W-2:0]].data_byte      = b;
         c.r[c.n[RES_CNT_W-2:0]].column_index   = col;
         c.r[c.n[RES_CNT_W-2:0]].header_row     = h;
         c.r[c.n[RES_CNT_W-2:0]].format_version = v;
         c.r[c.n[RES_CNT_W-2:0]].run_last       = 1'b0;
         c.n = c.n + 1'b1;
      end
      return c;
   endfunction

   function automatic logic supp(ctx_type c);
      return c.s.hdr_seen && !c.s.ffhb;
   endfunction

   function automatic ctx_type put_content(ctx_type c, logic [7:0] b);
      if (c.s.fpos == 8'd0) c.s.ffhb = 1'b1;
      if (!supp(c)) c = put(c, KIND_BYTE, b, c.s.fpos, !c.s.hdr_seen, '0);
      return c;
   endfunction

   function automatic ctx_type end_field(ctx_type c);
      if (!supp(c)) c = put(c, KIND_FIELD, '0, c.s.fpos, !c.s.hdr_seen, '0);
      return c;
   endfunction

   function automatic ctx_type next_field(ctx_type c);
      c = end_field(c);
      if (c.s.fpos < COL_CAP) c.s.fpos = c.s.fpos + 8'd1;
      c.s.phase = PH_FSTART;
      return c;
   endfunction

   function automatic ctx_type end_record(ctx_type c);
      c = end_field(c);
      if (!supp(c)) c = put(c, KIND_RECORD, '0, c.s.fpos, !c.s.hdr_seen, '0);
      c.s.hdr_seen = 1'b1;
      c.s.fpos     = '0;
      c.s.ffhb     = 1'b0;
      c.s.phase    = PH_LINE;
      return c;
   endfunction

   function automatic ctx_type close_digits(ctx_type c);
      if (c.s.dig) begin
         c.s.dig = 1'b0;
         if (c.s.acc != '0) begin
            c.s.ver_seen = 1'b1;
            c = put(c, KIND_VERSION, '0, '0, 1'b0, c.s.acc);
         end
      end
      return c;
   endfunction

   function automatic ctx_type comment_byte(ctx_type c, logic [7:0] b);
      if (c.s.dig) begin
         if (b >= CH_ZERO && b <= CH_NINE) begin
            // times ten as two shifts and an add
            c.s.acc = (c.s.acc << 3) + (c.s.acc << 1) + 30'(b - CH_ZERO);
            if (c.s.acc >= VER_LIMIT) c = close_digits(c);
         end else begin
            c = close_digits(c);
         end
      end else if (c.s.wmp < 3'd7) begin
         if (b == word_char(c.s.wmp)) begin
            c.s.wmp = c.s.wmp + 3'd1;
            if (c.s.wmp == 3'd7) begin
               c.s.dig = 1'b1;
               c.s.acc = '0;
            end
         end else begin
            c.s.wmp = (b == CH_F) ? 3'd1 : 3'd0;
         end
      end
      return c;
   endfunction

   function automatic ctx_type bare_byte(ctx_type c, logic [7:0] b, logic last);
      priority if (b == CH_LF) begin
         c = end_record(c);
      end else if (b == CH_CR) begin
         if (last) c = end_record(c);
         else c.s.cr_wait = 1'b1;
      end else if (b == CH_COMMA) begin
         c = next_field(c);
      end else begin
         c = put_content(c, b);
      end
      return c;
   endfunction

   function automatic ctx_type start_field(ctx_type c, logic [7:0] b, logic last);
      if (b == CH_QUOTE) begin
         c.s.phase = PH_QUOTED;
      end else begin
         c.s.phase = PH_BARE;
         c = bare_byte(c, b, last);
      end
      return c;
   endfunction

   function automatic ctx_type feed(ctx_type c, logic [7:0] b, logic last);
      unique case (c.s.phase)
         PH_LINE: begin
            priority if (b == CH_LF) begin
            end else if (b == CH_CR) begin
               if (!last) c.s.cr_wait = 1'b1;
            end else if (b == CH_HASH) begin
               c.s.phase = PH_COMMENT;
               c.s.wmp   = c.s.ver_seen ? 3'd7 : 3'd0;
               c.s.dig   = 1'b0;
               c.s.acc   = '0;
            end else begin
               c.s.fpos = '0;
               c.s.ffhb = 1'b0;
               c = start_field(c, b, last);
            end
         end
         PH_COMMENT: begin
            if (b == CH_LF) begin
               c = close_digits(c);
               c.s.phase = PH_LINE;
            end else begin
               c = comment_byte(c, b);
               if (b == CH_CR) begin
                  if (last) begin
                     c = close_digits(c);
                     c.s.phase = PH_LINE;
                  end else begin
                     c.s.cr_wait = 1'b1;
                  end
               end
            end
         end
         PH_FSTART: c = start_field(c, b, last);
         PH_QUOTED: begin
            if (b == CH_QUOTE) c.s.phase = PH_QSEEN;
            else c = put_content(c, b);
         end
         PH_QSEEN: begin
            if (b == CH_QUOTE) begin
               c = put_content(c, CH_QUOTE);
               c.s.phase = PH_QUOTED;
            end else begin
               c.s.phase = PH_BARE;
               c = bare_byte(c, b, last);
            end
         end
         default: begin
            c.s.phase = PH_BARE;
            c = bare_byte(c, b, last);
         end
      endcase
      return c;
   endfunction

   function automatic ctx_type resolve_cr(ctx_type c, logic [7:0] b, logic last);
      c.s.cr_wait = 1'b0;
      if (b == CH_LF) begin
         if (c.s.phase == PH_COMMENT) begin
            c = close_digits(c);
            c.s.phase = PH_LINE;
         end else if (c.s.phase != PH_LINE) begin
            c = end_record(c);
         end
      end else begin
         if (c.s.phase == PH_LINE) begin
            c.s.fpos  = '0;
            c.s.ffhb  = 1'b0;
            c.s.phase = PH_BARE;
            c = put_content(c, CH_CR);
         end else if (c.s.phase != PH_COMMENT) begin
            c = put_content(c, CH_CR);
         end
         c = feed(c, b, last);
      end
      return c;
   endfunction

   function automatic ctx_type finish(ctx_type c);
      if (c.s.phase == PH_COMMENT) c = close_digits(c);
      else if (c.s.phase != PH_LINE) c = end_record(c);
      c.s = '0;
      return c;
   endfunction

   function automatic logic [7:0] bom_char(logic [1:0] i);
      unique case (i)
         2'd0: bom_char = BOM_0;
         2'd1: bom_char = BOM_1;
         default: bom_char = BOM_2;
      endcase
   endfunction

   function automatic ctx_type step(state_type s, logic [7:0] b, logic last);
      ctx_type    c;
      logic [1:0] held;
      logic       done;
      c      = '0;
      c.s    = s;
      held   = s.bom;
      done   = 1'b0;
      if (s.bom != 2'd3) begin
         if (b == bom_char(held) && (held == 2'd2 || !last)) begin
            c.s.bom = held + 2'd1;
            if (last) c = finish(c);
            done = 1'b1;
         end else begin
            c.s.bom = 2'd3;
            if (held >= 2'd1) c = feed(c, BOM_0, 1'b0);
            if (held >= 2'd2) c = feed(c, BOM_1, 1'b0);
         end
      end
      if (!done) begin
         if (c.s.cr_wait) c = resolve_cr(c, b, last);
         else c = feed(c, b, last);
         if (last) c = finish(c);
         if (c.n != '0) c.r[3'(c.n - 1'b1)].run_last = 1'b1;
      end
      return c;
   endfunction

   ctx_type res_ctx;

   always_comb begin
      res_ctx = step(st, req.text_byte, req.end_of_text);
   end

   assign st_in = res_ctx.s;
   assign res   = res_ctx.r;
   assign res_n = res_ctx.n;

endmodule

[hw/rtl/csv_record_tokenizer.sv]
// Top level of the CSV record tokenizer: input register, core and result queue.
// Takes one text byte per item and turns it into zero to eight token items
// (field byte, field end, record end, version). A byte is registered on
// acceptance; the core then works out all its tokens at once and, once the
// queue is empty or its last token is leaving, loads them into an eight-entry
// result queue, which drains one token per cycle on the rsp_ port while
// rsp_ready is high. Plain field text, which yields at most one token per
// byte, streams at one byte per clock while rsp_ready is high; a byte that
// yields more tokens holds the input until the queue drains, the result port
// being the limit. A new byte is taken while the last token of the previous
// one is still waiting. end_of_text on a byte closes any open record and
// returns all parse state to its reset value. MAX_COLUMNS sets where
// column_index saturates (at MAX_COLUMNS-1, and never above 255).
module csv_record_tokenizer import csvtok_pkg::*; #(
   parameter int MAX_COLUMNS = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam logic [7:0] COL_CAP =
      (MAX_COLUMNS - 1 > 255) ? 8'd255 : 8'(MAX_COLUMNS - 1);

   req_type                in_ff;
   logic                   in_vld_ff;
   state_type              st_ff, st_in;
   rsp_list_type           buf_ff, buf_in, core_res;
   logic [RES_CNT_W-1:0]   cnt_ff, cnt_in, core_n;
   logic                   load, pop;

   csvtok_core #(.COL_CAP(COL_CAP)) u_core (
      .st    (st_ff),
      .req   (in_ff),
      .st_in (st_in),
      .res   (core_res),
      .res_n (core_n)
   );

   // Queue may be refilled once it is empty or its last token leaves now.
   assign pop  = rsp_valid && rsp_ready;
   assign load = in_vld_ff && (cnt_ff == '0 || (cnt_ff == RES_CNT_W'(1) && rsp_ready));
   assign req_ready = !in_vld_ff || load;

   assign rsp_valid = cnt_ff != '0;
   assign rsp_data  = buf_ff[0];

   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      if (load) begin
         buf_in = core_res;
         cnt_in = core_n;
      end else if (pop) begin
         for (int i = 0; i < RES_MAX - 1; i++) begin
            buf_in[i] = buf_ff[i+1];
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (req_valid && req_ready) in_ff <= req_data;
      if (reset) begin
         in_vld_ff <= 1'b0;
         cnt_ff    <= '0;
         st_ff     <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (load) st_ff <= st_in;
         if (req_ready) in_vld_ff <= req_valid;
      end
   end

endmodule

[hw/rtl/csvtok_checker.sv]
// Port checker for the CSV record tokenizer, bound to the top level.
module csvtok_checker import csvtok_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown straight after reset");

   a_version_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.token_kind == KIND_VERSION |->
         rsp_data.header_row == 1'b0 && rsp_data.column_index == 8'd0 &&
         rsp_data.format_version != '0)
      else $error("malformed version token");

   a_token_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.token_kind != KIND_VERSION |->
         rsp_data.format_version == '0 &&
         (rsp_data.token_kind == KIND_BYTE || rsp_data.data_byte == 8'd0))
      else $error("stray payload on token");

endmodule

bind csv_record_tokenizer csvtok_checker u_csvtok_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
